// File: rtl/core/tbts_pkg.sv
// tbts_pkg: shared types and constants of the thermistor temperature smoother
// depends on nothing
`default_nettype none
package tbts_pkg;
	localparam int unsigned AdcFull = 1023;
	localparam int unsigned KelvinOffset = 273;
	localparam int unsigned Percent = 100;
	localparam logic [31:0] Ln2Q32 = 32'd2977044472;
	localparam int unsigned NumRegs = 8;
	localparam int unsigned CfgIdxW = 4;
	localparam int unsigned CfgDataW = 24;
	// reciprocal of the percentage, exact for numerators below SatQuotient
	localparam logic [31:0] RecipPercent = 32'd167773;
	localparam int unsigned RecipShift = 24;
	// numerator in whole q.16 units at which the blended result saturates
	localparam int unsigned SatQuotient = 102400;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDIV,
		ST_NORM,
		ST_SQR,
		ST_SQR_WAIT,
		ST_LN,
		ST_LN_WAIT,
		ST_TDIV,
		ST_BLEND,
		ST_BLEND_WAIT,
		ST_BDIV,
		ST_DONE
	} tbts_state_t;

	typedef enum logic [1:0] {
		MUL_SQR,
		MUL_LN,
		MUL_BLEND
	} tbts_mul_op_t;

	// request to the shared divider
	typedef struct packed {
		logic start;
		logic neg;
		logic [79:0] num;
		logic [79:0] den;
	} tbts_div_req_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
		logic [79:0] quo;
	} tbts_div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/tbts_if.sv
// tbts_if: valid/ready channels for the input and result items
// depends on nothing
`default_nettype none
interface tbts_in_if;
	logic valid;
	logic ready;
	logic [1:0] channel;
	logic [9:0] adc_sample;
	modport source (output valid, channel, adc_sample, input ready);
	modport sink (input valid, channel, adc_sample, output ready);
endinterface

interface tbts_out_if;
	logic valid;
	logic ready;
	logic [1:0] channel_out;
	logic signed [10:0] temperature_c;
	logic sample_invalid;
	modport source (output valid, channel_out, temperature_c, sample_invalid, input ready);
	modport sink (input valid, channel_out, temperature_c, sample_invalid, output ready);
endinterface
`default_nettype wire

// File: rtl/core/thermistor_beta_temperature_smoother_top.sv
// thermistor_beta_temperature_smoother_top: sequencer, registers and state
// depends on tbts_pkg, tbts_if, tbts_div, tbts_mul
//
// usage: in_ch carries an item (channel, adc_sample); out_ch returns one item
// per input (channel_out, temperature_c, sample_invalid). The block takes one
// item at a time: ready is low from acceptance until its result is taken.
// A valid sample runs through a divide for the resistance, a normalise
// step, 16 squarings on the shared multiplier, a log step, a divide for
// kelvin, a blend (the percentage by reciprocal multiply) and the output
// step. The shared divider produces one bit a cycle. Samples of 0 or
// full scale and unknown channels go straight to the output step, a zero
// resistance after the first divide and a zero log difference after the
// log step, with the state untouched except for the latter. The result
// holds in an output register while the receiver stalls.
// Reset sets beta to 3950, offsets to -264765 (Q.16) and the stored
// temperatures to zero. cfg_we writes register cfg_index (0..3 beta,
// 4..7 log offset) with cfg_data; other indexes are ignored.
//
`default_nettype none
module thermistor_beta_temperature_smoother_top
	import tbts_pkg::*;
#(
	parameter int unsigned CHANNELS = 4,
	parameter int unsigned REF_RESISTANCE = 10000,
	parameter int unsigned SMOOTH_WEIGHT = 90
) (
	input wire logic clk,
	input wire logic arst_n,
	tbts_in_if.sink in_ch,
	tbts_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [CfgIdxW-1:0] cfg_index,
	input wire logic [CfgDataW-1:0] cfg_data
);
	localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	tbts_state_t state_q, state_d;
	logic [15:0] beta_q [4];
	logic [23:0] offs_q [4];
	logic signed [10:0] temp_q [CHANNELS];

	logic [1:0] ch_q;
	logic [39:0] r_q;
	logic [5:0] k_q;
	logic [31:0] m_q;
	logic [15:0] frac_q;
	logic [4:0] it_q;
	logic signed [63:0] c_q;
	logic [16:0] q16_q;
	logic sat_q, bneg_q;
	logic [63:0] mp;
	logic [31:0] ma, mb;
	logic [10:0] res_q;
	logic inv_q, ovalid_q;
	tbts_div_req_t dreq;
	tbts_div_rsp_t drsp;

	tbts_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));
	tbts_mul u_mul (.clk, .a(ma), .b(mb), .p(mp));

	logic ch_ok;
	logic [ChW-1:0] ch_idx;
	assign ch_ok = ({2'b0, ch_q} < 4'(CHANNELS));
	assign ch_idx = ChW'(ch_q);
	logic signed [10:0] stored;
	assign stored = ch_ok ? temp_q[ch_idx] : 11'sd0;

	logic ch_ok_in;
	assign ch_ok_in = ({2'b0, in_ch.channel} < 4'(CHANNELS));
	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;

	// top bit index of resistance
	logic [5:0] msb;
	always_comb begin
		msb = '0;
		for (int i = 0; i < 40; i++) if (r_q[i]) msb = 6'(i);
	end

	// log2 into natural log, rounded
	logic [63:0] l2;
	assign l2 = {42'd0, k_q[5:0], frac_q};
	logic signed [31:0] lnr;
	assign lnr = 32'(({32'd0, mp} + 96'h8000_0000) >> 32);

	// log difference against the channel offset
	logic signed [31:0] dlog;
	logic [31:0] dmag;
	assign dlog = lnr - $signed({{8{offs_q[ch_q][23]}}, offs_q[ch_q]});
	assign dmag = dlog[31] ? 32'(-dlog) : 32'(dlog);

	// operands of the shared multiplier
	always_comb begin
		ma = m_q;
		mb = m_q;
		if (state_q == ST_LN) begin
			ma = l2[31:0];
			mb = Ln2Q32;
		end else if (state_q == ST_BLEND_WAIT) begin
			ma = 32'(q16_q);
			mb = RecipPercent;
		end
	end

	// blend numerator and its magnitude
	logic signed [63:0] prod_s, num_s, wstore;
	logic [63:0] num_mag;
	assign prod_s = c_q * $signed(64'(Percent - SMOOTH_WEIGHT));
	assign wstore = 64'(signed'(SMOOTH_WEIGHT)) * 64'(stored) * 64'sd65536;
	assign num_s = prod_s + wstore;
	assign num_mag = num_s[63] ? 64'(-num_s) : 64'(num_s);

	// divider requests
	always_comb begin
		dreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				dreq.start = in_ch.valid && in_ch.ready && ch_ok_in
					&& in_ch.adc_sample != 10'd0 && in_ch.adc_sample != 10'(AdcFull);
				dreq.num = 80'(64'(AdcFull - in_ch.adc_sample) * 64'(REF_RESISTANCE));
				dreq.den = 80'(in_ch.adc_sample);
			end
			ST_LN_WAIT: begin
				dreq.start = (dlog != 32'sd0);
				dreq.num = {32'd0, beta_q[ch_q], 32'd0};
				dreq.den = {48'd0, dmag};
				dreq.neg = dlog[31];
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) state_d = dreq.start ? ST_RDIV : ST_DONE;
			ST_RDIV: if (drsp.done) state_d = (drsp.quo == 80'd0) ? ST_DONE : ST_NORM;
			ST_NORM: state_d = ST_SQR;
			ST_SQR: state_d = ST_SQR_WAIT;
			ST_SQR_WAIT: state_d = (it_q == 5'd15) ? ST_LN : ST_SQR;
			ST_LN: state_d = ST_LN_WAIT;
			ST_LN_WAIT: state_d = dreq.start ? ST_TDIV : ST_DONE;
			ST_TDIV: if (drsp.done) state_d = ST_BLEND;
			ST_BLEND: state_d = ST_BLEND_WAIT;
			ST_BLEND_WAIT: state_d = ST_BDIV;
			ST_BDIV: state_d = ST_DONE;
			ST_DONE: if (!ovalid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// quotient by the percentage, saturated to 11 bits
	logic [10:0] bq, blend_res;
	assign bq = mp[RecipShift +: 11];
	assign blend_res = sat_q ? (bneg_q ? 11'h400 : 11'h3FF)
		: (bneg_q ? (~bq + 11'd1) : bq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				beta_q[i] <= 16'd3950;
				offs_q[i] <= 24'hFBF5C3;
			end
			for (int i = 0; i < CHANNELS; i++) temp_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index < CfgIdxW'(4)) beta_q[cfg_index[1:0]] <= cfg_data[15:0];
				else if (cfg_index < CfgIdxW'(NumRegs)) offs_q[cfg_index[1:0]] <= cfg_data;
			end
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			if (state_q == ST_DONE && !ovalid_q) begin
				ovalid_q <= 1'b1;
				if (!inv_q && ch_ok) temp_q[ch_idx] <= res_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready) begin
				ch_q <= in_ch.channel;
				inv_q <= 1'b1;
				res_q <= ch_ok_in ? 11'(temp_q[ChW'(in_ch.channel)]) : 11'd0;
			end
			ST_RDIV: if (drsp.done) r_q <= drsp.quo[39:0];
			ST_NORM: begin
				k_q <= msb;
				m_q <= 32'(({32'd0, r_q} << 30) >> msb);
				frac_q <= '0;
				it_q <= '0;
			end
			ST_SQR_WAIT: begin
				it_q <= it_q + 5'd1;
				if (mp[61]) begin
					m_q <= mp[62:31];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q <= mp[61:30];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			ST_LN_WAIT: if (!dreq.start) begin
				res_q <= 11'd1023;
				inv_q <= 1'b0;
			end
			ST_TDIV: if (drsp.done) c_q <= $signed(drsp.quo[63:0]) - 64'sd17891328;
			ST_BLEND: begin
				q16_q <= num_mag[32:16];
				sat_q <= (num_mag[63:16] >= 48'(SatQuotient));
				bneg_q <= num_s[63];
			end
			ST_BDIV: begin
				res_q <= blend_res;
				inv_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.channel_out = ch_q;
	assign out_ch.temperature_c = res_q;
	assign out_ch.sample_invalid = inv_q;

	// only one item in flight
	assert property (@(posedge clk) disable iff (!arst_n) out_ch.valid |-> !in_ch.ready)
		else $error("input taken while result pending");
	// divider never restarted while busy
	assert property (@(posedge clk) disable iff (!arst_n) dreq.start |-> !drsp.busy)
		else $error("divider restarted while busy");
	// a result appears only from the done state
	assert property (@(posedge clk) disable iff (!arst_n) $rose(ovalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result without completion");
endmodule
`default_nettype wire

// File: rtl/core/tbts_div.sv
// tbts_div: shared restoring divider, one quotient bit per cycle, magnitudes
// depends on tbts_pkg
`default_nettype none
module tbts_div
	import tbts_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire tbts_div_req_t req,
	output tbts_div_rsp_t rsp
);
	logic [79:0] rem_q, quo_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic [80:0] trial;

	// shift-subtract step
	always_comb begin
		trial = {rem_q, quo_q[79]} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd80;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[80]) begin
				rem_q <= trial[79:0];
				quo_q <= {quo_q[78:0], 1'b1};
			end else begin
				rem_q <= {rem_q[78:0], quo_q[79]};
				quo_q <= {quo_q[78:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = neg_q ? (~quo_q + 80'd1) : quo_q;
endmodule
`default_nettype wire

// File: rtl/core/tbts_mul.sv
// tbts_mul: shared 32x32 multiplier with registered product
// depends on tbts_pkg
`default_nettype none
module tbts_mul
	import tbts_pkg::*;
(
	input wire logic clk,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	output logic [63:0] p
);
	// single multiply, result registered
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire
